// ===== hw/rtl/mci_pkg.sv =====
// ----------------------------------------------------------------------------
// mci_pkg
// Shared codes, sequencer types and cofactor index tables for the 4x4
// matrix cofactor inverse unit.
// ----------------------------------------------------------------------------
package mci_pkg;

  localparam logic       REG_RESULT_MODE = 1'b0;
  localparam logic       REG_SING_THRESH = 1'b1;

  localparam logic [1:0] MODE_INVERSE    = 2'd0;
  localparam logic [1:0] MODE_ADJUGATE   = 2'd1;

  localparam logic [3:0] LAST_IDX        = 4'd15;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OPA,
    ST_OPB,
    ST_MUL,
    ST_NEXT,
    ST_SING,
    ST_DIV,
    ST_QUO,
    ST_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    PH_MINOR,
    PH_DET,
    PH_ADJ
  } phase_t;

  localparam logic [3:0] MINOR_IDX [6][4] = '{
    '{4'd0, 4'd5, 4'd1, 4'd4},
    '{4'd0, 4'd6, 4'd2, 4'd4},
    '{4'd0, 4'd7, 4'd3, 4'd4},
    '{4'd1, 4'd6, 4'd2, 4'd5},
    '{4'd1, 4'd7, 4'd3, 4'd5},
    '{4'd2, 4'd7, 4'd3, 4'd6}
  };

  localparam logic [3:0] ADJ_ENT [16][3] = '{
    '{4'd5,  4'd6,  4'd7 }, '{4'd1,  4'd2,  4'd3 },
    '{4'd13, 4'd14, 4'd15}, '{4'd9,  4'd10, 4'd11},
    '{4'd4,  4'd6,  4'd7 }, '{4'd0,  4'd2,  4'd3 },
    '{4'd12, 4'd14, 4'd15}, '{4'd8,  4'd10, 4'd11},
    '{4'd4,  4'd5,  4'd7 }, '{4'd0,  4'd1,  4'd3 },
    '{4'd12, 4'd13, 4'd15}, '{4'd8,  4'd9,  4'd11},
    '{4'd4,  4'd5,  4'd6 }, '{4'd0,  4'd1,  4'd2 },
    '{4'd12, 4'd13, 4'd14}, '{4'd8,  4'd9,  4'd10}
  };

  localparam logic [3:0] ADJ_MIN [16][3] = '{
    '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd10, 4'd9},
    '{4'd5,  4'd4,  4'd3}, '{4'd5,  4'd4,  4'd3},
    '{4'd11, 4'd8,  4'd7}, '{4'd11, 4'd8,  4'd7},
    '{4'd5,  4'd2,  4'd1}, '{4'd5,  4'd2,  4'd1},
    '{4'd10, 4'd8,  4'd6}, '{4'd10, 4'd8,  4'd6},
    '{4'd4,  4'd2,  4'd0}, '{4'd4,  4'd2,  4'd0},
    '{4'd9,  4'd7,  4'd6}, '{4'd9,  4'd7,  4'd6},
    '{4'd3,  4'd1,  4'd0}, '{4'd3,  4'd1,  4'd0}
  };

endpackage

// ===== hw/rtl/mci_fifo.sv =====
// ----------------------------------------------------------------------------
// mci_fifo
// Short first-in first-out queue between the load front end and the
// compute engine.
// ----------------------------------------------------------------------------
module mci_fifo #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mci_front.sv =====
// ----------------------------------------------------------------------------
// mci_front
// Entry intake: tags each matrix entry with its row-major position and
// holds the configuration registers.
// ----------------------------------------------------------------------------
module mci_front #(
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ENTRY_WIDTH-1:0] in_entry,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [ENTRY_WIDTH-2:0] cfg_wdata,
  output logic                   push,
  output logic [ENTRY_WIDTH+3:0] push_word,
  input  logic                   q_full,
  output logic [1:0]             mode,
  output logic [ENTRY_WIDTH-2:0] thresh
);

  import mci_pkg::*;

  logic [3:0]             load_count_r, load_count_nxt;
  logic [1:0]             mode_r;
  logic [ENTRY_WIDTH-2:0] thresh_r;

  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign push_word = {load_count_r, in_entry};
  assign mode      = mode_r;
  assign thresh    = thresh_r;

  always_comb begin
    load_count_nxt = load_count_r;
    if (push) begin
      load_count_nxt = load_count_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      mode_r       <= MODE_INVERSE;
      thresh_r     <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RESULT_MODE: mode_r   <= cfg_wdata[1:0];
          REG_SING_THRESH: thresh_r <= cfg_wdata;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/mci_back.sv =====
// ----------------------------------------------------------------------------
// mci_back
// Compute engine: bit-serial multiply-accumulate over minors, determinant
// and adjugate, restoring divider for the inverse, saturating output stage.
// ----------------------------------------------------------------------------
module mci_back #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [ENTRY_WIDTH+3:0] q_data,
  output logic                   q_pop,
  input  logic [1:0]             mode,
  input  logic [ENTRY_WIDTH-2:0] thresh,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ENTRY_WIDTH-1:0] out_data,
  output logic                   out_sing,
  output logic                   out_last
);

  import mci_pkg::*;

  localparam int E    = ENTRY_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MW   = 2 * E + 1;
  localparam int DW   = 2 * MW + 3;
  localparam int AW   = E + MW + 2;
  localparam int NW   = AW + 2 * F;
  localparam int TW   = E - 1 + 3 * F;
  localparam int LW   = (DW > TW) ? DW : TW;
  localparam int SATW = (DW > NW + 1) ? DW : NW + 1;
  localparam int CNTW = $clog2(NW);

  function automatic logic [E-1:0] sat_e(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] smax;
    logic signed [SATW-1:0] smin;
    smax = {{(SATW-E+1){1'b0}}, {(E-1){1'b1}}};
    smin = ~smax;
    if (v > smax) begin
      sat_e = smax[E-1:0];
    end else if (v < smin) begin
      sat_e = smin[E-1:0];
    end else begin
      sat_e = v[E-1:0];
    end
  endfunction

  logic [E-1:0]           e_r  [16];
  logic [MW-1:0]          mn_r [12];

  bk_state_t              state_r, state_nxt;
  phase_t                 ph_r, ph_nxt;
  logic [3:0]             k_r, k_nxt;
  logic [2:0]             t_r, t_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic signed [DW-1:0]   acc_r, acc_nxt;
  logic [DW-1:0]          a_sh_r, a_sh_nxt;
  logic [MW-1:0]          b_sh_r, b_sh_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [DW-1:0]   det_r, det_nxt;
  logic [DW-1:0]          mag_r, mag_nxt;
  logic                   sing_r, sing_nxt;
  logic [NW-1:0]          num_r, num_nxt;
  logic [DW-1:0]          rem_r, rem_nxt;
  logic [NW-1:0]          q_r, q_nxt;
  logic                   qneg_r, qneg_nxt;
  logic [E-1:0]           res_r, res_nxt;
  logic                   last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [E-1:0]           out_data_r;
  logic                   out_sing_r, out_last_r;

  logic [3:0]             e_addr, mn_addr;
  logic [E-1:0]           e_rd;
  logic [MW-1:0]          mn_rd;
  logic [2:0]             k6;
  logic                   opb, use_mn, term_neg, last_term, adj_pos, sub;
  logic [DW-1:0]          op_val;
  logic                   e_we, mn_we, out_load, out_free;
  logic [DW-1:0]          mag_c, abs_acc;
  logic [DW:0]            rem_sh;
  logic                   ge;
  logic signed [NW:0]     qs;

  assign q_pop     = (state_r == ST_LOAD) && q_valid;
  assign e_we      = q_pop;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_sing  = out_sing_r;
  assign out_last  = out_last_r;

  assign k6      = (k_r >= 4'd6) ? 3'(k_r - 4'd6) : k_r[2:0];
  assign opb     = (state_r == ST_OPB);
  assign adj_pos = !(k_r[2] ^ k_r[0]);
  assign e_rd    = e_r[e_addr];
  assign mn_rd   = mn_r[mn_addr];

  always_comb begin
    e_addr    = '0;
    mn_addr   = '0;
    use_mn    = 1'b0;
    term_neg  = 1'b0;
    last_term = 1'b0;
    unique case (ph_r)
      PH_MINOR: begin
        e_addr    = MINOR_IDX[k6][{t_r[0], opb}] + ((k_r >= 4'd6) ? 4'd8 : 4'd0);
        term_neg  = (t_r == 3'd1);
        last_term = (t_r == 3'd1);
      end
      PH_DET: begin
        mn_addr   = opb ? (4'd11 - {1'b0, t_r}) : {1'b0, t_r};
        use_mn    = 1'b1;
        term_neg  = (t_r == 3'd1) || (t_r == 3'd4);
        last_term = (t_r == 3'd5);
      end
      PH_ADJ: begin
        e_addr    = ADJ_ENT[k_r][t_r[1:0]];
        mn_addr   = ADJ_MIN[k_r][t_r[1:0]];
        use_mn    = opb;
        term_neg  = (adj_pos != (t_r != 3'd1));
        last_term = (t_r == 3'd2);
      end
      default: begin
        e_addr = '0;
      end
    endcase
  end

  assign op_val  = use_mn ? {{(DW-MW){mn_rd[MW-1]}}, mn_rd} : {{(DW-E){e_rd[E-1]}}, e_rd};
  assign sub     = (cnt_r == CNTW'(MW - 1)) ^ neg_r;
  assign mag_c   = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
  assign abs_acc = acc_r[DW-1] ? DW'(-acc_r) : DW'(acc_r);
  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign ge      = (rem_sh >= {1'b0, mag_r});
  assign qs      = qneg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    a_sh_nxt  = a_sh_r;
    b_sh_nxt  = b_sh_r;
    neg_nxt   = neg_r;
    det_nxt   = det_r;
    mag_nxt   = mag_r;
    sing_nxt  = sing_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    qneg_nxt  = qneg_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    mn_we     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (q_valid && (q_data[E+3:E] == LAST_IDX)) begin
          ph_nxt    = PH_MINOR;
          k_nxt     = '0;
          t_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_OPA;
        end
      end
      ST_OPA: begin
        a_sh_nxt  = op_val;
        state_nxt = ST_OPB;
      end
      ST_OPB: begin
        b_sh_nxt  = op_val[MW-1:0];
        neg_nxt   = term_neg;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (b_sh_r[0]) begin
          acc_nxt = sub ? acc_r - $signed(a_sh_r) : acc_r + $signed(a_sh_r);
        end
        a_sh_nxt = a_sh_r << 1;
        b_sh_nxt = b_sh_r >> 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNTW'(MW - 1)) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!last_term) begin
          t_nxt     = t_r + 3'd1;
          state_nxt = ST_OPA;
        end else begin
          t_nxt   = '0;
          acc_nxt = '0;
          unique case (ph_r)
            PH_MINOR: begin
              mn_we     = 1'b1;
              state_nxt = ST_OPA;
              if (k_r == 4'd11) begin
                ph_nxt = PH_DET;
                k_nxt  = '0;
              end else begin
                k_nxt = k_r + 4'd1;
              end
            end
            PH_DET: begin
              det_nxt   = acc_r;
              state_nxt = ST_SING;
            end
            PH_ADJ: begin
              last_nxt = (k_r == LAST_IDX);
              qneg_nxt = acc_r[DW-1] ^ det_r[DW-1];
              num_nxt  = {abs_acc[AW-1:0], {(2*F){1'b0}}};
              rem_nxt  = '0;
              q_nxt    = '0;
              cnt_nxt  = '0;
              if (mode == MODE_ADJUGATE) begin
                res_nxt   = sat_e(SATW'(acc_r >>> (2 * F)));
                state_nxt = ST_EMIT;
              end else if (sing_r) begin
                res_nxt   = '0;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_DIV;
              end
            end
            default: begin
              state_nxt = ST_LOAD;
            end
          endcase
        end
      end
      ST_SING: begin
        mag_nxt  = mag_c;
        sing_nxt = (LW'(mag_c) <= LW'({thresh, {(3*F){1'b0}}}));
        if (mode[1]) begin
          res_nxt   = sat_e(SATW'(det_r >>> (3 * F)));
          last_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          ph_nxt    = PH_ADJ;
          k_nxt     = '0;
          t_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_OPA;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? DW'(rem_sh - {1'b0, mag_r}) : rem_sh[DW-1:0];
        q_nxt   = {q_r[NW-2:0], ge};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          state_nxt = ST_QUO;
        end
      end
      ST_QUO: begin
        res_nxt   = sat_e(SATW'(qs));
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if ((ph_r == PH_ADJ) && !mode[1] && (k_r != LAST_IDX)) begin
            k_nxt     = k_r + 4'd1;
            t_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_OPA;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ph_r        <= PH_MINOR;
      k_r         <= '0;
      t_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      k_r         <= k_nxt;
      t_r         <= t_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    a_sh_r <= a_sh_nxt;
    b_sh_r <= b_sh_nxt;
    neg_r  <= neg_nxt;
    det_r  <= det_nxt;
    mag_r  <= mag_nxt;
    sing_r <= sing_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    qneg_r <= qneg_nxt;
    res_r  <= res_nxt;
    last_r <= last_nxt;
    if (e_we) begin
      e_r[q_data[E+3:E]] <= q_data[E-1:0];
    end
    if (mn_we) begin
      mn_r[k_r] <= acc_r[MW-1:0];
    end
    if (out_load) begin
      out_data_r <= res_r;
      out_sing_r <= sing_r;
      out_last_r <= last_r;
    end
  end

endmodule

// ===== hw/rtl/matrix4_cofactor_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_cofactor_inverse_unit
// 4x4 fixed-point determinant, adjugate and inverse by cofactor expansion.
// ----------------------------------------------------------------------------
// Entries stream in one word per cycle through a four-word queue. While a
// matrix is being worked, only the first four entries of the next one are
// taken; the rest load at one word per cycle once the engine is free again.
// Compute runs on one shared bit-serial multiply-accumulate unit: 78 products
// (24 for the minors, 6 for the determinant, 48 for the adjugate), one at a
// time. Determinant-only mode skips the adjugate products. Inverse mode adds
// a restoring division for each result of a non-singular matrix. All
// intermediates are exact; every result saturates to the signed ENTRY_WIDTH
// range.
module matrix4_cofactor_inverse_unit #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((ENTRY_WIDTH+7)/8)*8-1:0]   in_tdata,   // entry_value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((ENTRY_WIDTH+7)/8)*8-1:0]   out_tdata,  // result_value
  output logic                               out_tuser,  // singular
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [ENTRY_WIDTH-2:0]             cfg_wdata
);

  import mci_pkg::*;

  localparam int DATAW = ((ENTRY_WIDTH + 7) / 8) * 8;
  localparam int QW    = ENTRY_WIDTH + 4;

  logic                   push, q_full, q_pop, q_valid;
  logic [QW-1:0]          push_word, q_data;
  logic [1:0]             mode;
  logic [ENTRY_WIDTH-2:0] thresh;
  logic [ENTRY_WIDTH-1:0] res_data;

  mci_front #(
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_entry  (in_tdata[ENTRY_WIDTH-1:0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full),
    .mode      (mode),
    .thresh    (thresh)
  );

  mci_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .valid     (q_valid)
  );

  mci_back #(
    .ENTRY_WIDTH(ENTRY_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .mode      (mode),
    .thresh    (thresh),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_data),
    .out_sing  (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = DATAW'(res_data);

endmodule

// ===== verif/tb_matrix4_cofactor_inverse_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_cofactor_inverse_unit
// Streams 4x4 Q16.16 matrices into the cofactor inverse unit. Each result word
// is checked against an exact 256-bit cofactor model built in this bench.
// ----------------------------------------------------------------------------
// Directed matrices come first: identity, scaled diagonal, zero, rank-deficient
// and full-range entries, in every result mode. Random matrices and random
// register settings follow. Both stream sides idle and stall at random.
module tb_matrix4_cofactor_inverse_unit;
  import mci_pkg::*;

  localparam logic [1:0] MODE_DETERMINANT = 2'd2;
  localparam logic [1:0] MODE_UNUSED      = 2'd3;
  localparam int         IDLE_LIMIT       = 40000;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic [31:0] value;
    logic        singular;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = REG_RESULT_MODE;
  logic [30:0] cfg_wdata = '0;

  logic [31:0]  entry_queue[$];
  result_word_t result_queue[$];
  logic [1:0]   mode_shadow = MODE_INVERSE;
  logic [30:0]  thresh_shadow = '0;
  logic signed [31:0] matrix_buf[16];
  int           load_idx = 0;
  int           in_gap = 0;
  int           out_stall = 0;
  bit           burst = 1'b0;
  int           fails = 0;
  int           idle_cycles = 0;
  wide_t        mw[16];

  matrix4_cofactor_inverse_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (burst || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] saturate(wide_t x);
    if (x > 256'sh7fffffff) return 32'h7fffffff;
    if (x < -256'sh80000000) return 32'h80000000;
    return x[31:0];
  endfunction

  // 3x3 determinant of mw with row r and column c removed
  function automatic wide_t cofactor_det(int r, int c);
    wide_t a[3][3];
    int ri;
    int ci;
    ri = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != r) begin
        ci = 0;
        for (int j = 0; j < 4; j++) begin
          if (j != c) begin
            a[ri][ci] = mw[i*4+j];
            ci++;
          end
        end
        ri++;
      end
    end
    return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
         - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
         + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
  endfunction

  function automatic void predict_matrix();
    wide_t cof[16];
    wide_t det;
    wide_t mag;
    wide_t lim;
    wide_t adj;
    wide_t q;
    logic sing;
    result_word_t w;
    for (int i = 0; i < 16; i++) mw[i] = matrix_buf[i];
    det = '0;
    for (int i = 0; i < 16; i++) begin
      cof[i] = cofactor_det(i / 4, i % 4);
      if (((i / 4) + (i % 4)) % 2 == 1) cof[i] = -cof[i];
    end
    for (int c = 0; c < 4; c++) det += mw[c] * cof[c];
    mag = (det < 0) ? -det : det;
    lim = '0;
    lim[30:0] = thresh_shadow;
    lim = lim << 48;
    sing = (mag <= lim);
    if (mode_shadow == MODE_DETERMINANT || mode_shadow == MODE_UNUSED) begin
      w.value = saturate(det >>> 48);
      w.singular = sing;
      w.last = 1'b1;
      result_queue.push_back(w);
      return;
    end
    for (int i = 0; i < 16; i++) begin
      adj = cof[(i % 4) * 4 + i / 4];
      w.value = '0;
      if (mode_shadow == MODE_ADJUGATE) begin
        w.value = saturate(adj >>> 32);
      end else if (!sing) begin
        q = (((adj < 0) ? -adj : adj) << 32) / mag;
        if ((adj < 0) != (det < 0)) q = -q;
        w.value = saturate(q);
      end
      w.singular = sing;
      w.last = (i == 15);
      result_queue.push_back(w);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        matrix_buf[load_idx] = in_tdata;
        if (load_idx == 15) begin
          load_idx = 0;
          predict_matrix();
        end else begin
          load_idx++;
        end
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (entry_queue.size() > 0) begin
        in_tdata <= entry_queue.pop_front();
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result word: value %h", out_tdata);
        fails++;
      end else begin
        w = result_queue.pop_front();
        if (out_tdata !== w.value) begin
          $error("result_value: expected %h, got %h", w.value, out_tdata);
          fails++;
        end
        if (out_tuser !== w.singular) begin
          $error("singular: expected %b, got %b", w.singular, out_tuser);
          fails++;
        end
        if (out_tlast !== w.last) begin
          $error("last: expected %b, got %b", w.last, out_tlast);
          fails++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (entry_queue.size() > 0 || in_tvalid || result_queue.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_regs(logic [1:0] mode, logic [30:0] thresh);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_RESULT_MODE;
    cfg_wdata <= 31'(mode);
    mode_shadow <= mode;
    @(posedge clk);
    cfg_addr <= REG_SING_THRESH;
    cfg_wdata <= thresh;
    thresh_shadow <= thresh;
    @(posedge clk);
    cfg_we <= 1'b0;
    burst = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [31:0] small_entry();
    return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  // kinds: 0 small, 1 full range, 2 rank deficient, 3 near identity, 4 integer
  task automatic push_matrix(int kind);
    logic [31:0] m[16];
    for (int i = 0; i < 16; i++) begin
      case (kind)
        1: m[i] = $urandom();
        3: m[i] = ((i % 5 == 0) ? 32'h0001_0000 : 32'h0)
                + 32'($signed($urandom_range(0, 8191)) - 4096);
        4: m[i] = 32'($signed($urandom_range(0, 14)) - 7) << 16;
        default: m[i] = small_entry();
      endcase
    end
    if (kind == 2) for (int j = 0; j < 4; j++) m[4+j] = m[j];
    for (int i = 0; i < 16; i++) entry_queue.push_back(m[i]);
  endtask

  task automatic push_fill(logic [31:0] diag, logic [31:0] off);
    for (int i = 0; i < 16; i++) entry_queue.push_back((i % 5 == 0) ? diag : off);
  endtask

  initial begin
    logic [30:0] th;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_regs(MODE_INVERSE, '0);
    push_fill(32'h0001_0000, 32'h0);
    push_fill(32'h0002_0000, 32'h0);
    push_fill(32'hffff_8000, 32'h0000_0001);
    push_fill(32'h0, 32'h0);
    push_fill(32'h0000_0001, 32'h0);
    push_matrix(2);
    write_regs(MODE_ADJUGATE, 31'h7fffffff);
    push_fill(32'h7fff_ffff, 32'h8000_0000);
    push_matrix(1);
    write_regs(MODE_DETERMINANT, 31'h0001_0000);
    push_fill(32'h8000_0000, 32'h7fff_ffff);
    push_matrix(3);
    write_regs(MODE_UNUSED, '0);
    push_fill(32'h7fff_ffff, 32'h0);
    write_regs(MODE_INVERSE, 31'h7fffffff);
    push_matrix(0);

    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0: th = '0;
        1: th = 31'h7fffffff;
        2: th = 31'($urandom_range(0, 1 << 18));
        default: th = 31'($urandom());
      endcase
      write_regs(2'($urandom_range(0, 3)), th);
      repeat (2) push_matrix($urandom_range(0, 4));
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mci_pkg.sv
hw/rtl/mci_fifo.sv
hw/rtl/mci_front.sv
hw/rtl/mci_back.sv
hw/rtl/matrix4_cofactor_inverse_unit.sv
verif/tb_matrix4_cofactor_inverse_unit.sv
